/* hw/rtl/bxf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxf_pkg
// Shared types and constants of the box FIR filter.
// ----------------------------------------------------------------------------
package bxf_pkg;

    localparam int unsigned TAPS_DEF   = 1024;
    localparam int unsigned SAMPLE_W   = 32;
    localparam int unsigned GAIN_W     = 32;
    localparam logic [31:0] GAIN_RESET = 32'd2097152;   // 1/1024 in units of 2^-31

    // result buffer depth; must exceed the datapath latency
    localparam int unsigned FIFO_DEPTH = 8;

    typedef struct packed {
        logic        sat;
        logic [31:0] value;
    } t_res;

endpackage

/* hw/rtl/bxf_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxf_ring
// Sample history ring memory and the exact running sum of its contents.
// ----------------------------------------------------------------------------
module bxf_ring #(
    parameter int unsigned TAPS = bxf_pkg::TAPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [31:0]                     i_sample,
    output logic                            o_valid,
    output logic signed [32+$clog2(TAPS)-1:0] o_sum
);

    localparam int unsigned PW    = $clog2(TAPS);
    localparam int unsigned SUM_W = 32 + PW;

    logic [31:0]              r_mem [TAPS];
    logic [31:0]              r_rd_data;
    logic [PW-1:0]            r_pos;
    logic                     r_wrapped;
    logic                     r_s1_valid;
    logic                     r_s1_live;
    logic [31:0]              r_s1_sample;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_sum_valid;
    logic [31:0]              w_old;
    logic signed [SUM_W-1:0]  n_sum;

    // read-before-write on the same slot: the read returns the oldest sample
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd_data      <= r_mem[r_pos];
            r_mem[r_pos]   <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_sample <= i_sample;
            r_s1_live   <= r_wrapped;
        end
    end

    // slots not yet written since reset read as zero until the first wrap
    assign w_old = r_s1_live ? r_rd_data : 32'd0;

    assign n_sum = r_sum
                 - {{(SUM_W-32){w_old[31]}}, w_old}
                 + {{(SUM_W-32){r_s1_sample[31]}}, r_s1_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_wrapped   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_sum       <= '0;
            r_sum_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_sum_valid <= r_s1_valid;
            if (i_valid) begin
                if (r_pos == PW'(TAPS - 1)) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (r_s1_valid) begin
                r_sum <= n_sum;
            end
        end
    end

    assign o_valid = r_sum_valid;
    assign o_sum   = r_sum;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(TAPS - 1))
        else $error("ring position out of range");

    a_live_after_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_wrapped) |=> r_s1_live)
        else $error("wrapped ring read not marked live");

endmodule

/* hw/rtl/bxf_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxf_scale
// Gain multiply, round half away from zero and saturate to Q1.31.
// ----------------------------------------------------------------------------
module bxf_scale #(
    parameter int unsigned SUM_W = 42
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [31:0]             i_gain,
    output logic                    o_valid,
    output bxf_pkg::t_res           o_res
);

    localparam int unsigned PP_W   = SUM_W + 16;
    localparam int unsigned PROD_W = SUM_W + 33;
    localparam int unsigned RND_W  = PROD_W - 31;

    logic               r_p2_valid, r_p3_valid, r_p4_valid, r_p5_valid;
    logic               r_p2_neg, r_p3_neg, r_p4_neg;
    logic [SUM_W-1:0]   r_mag;
    logic [PP_W-1:0]    r_pq;
    logic [PP_W-1:0]    r_pa;
    logic [RND_W-1:0]   r_rnd;
    bxf_pkg::t_res      r_res;
    logic [PROD_W-1:0]  w_full;
    bxf_pkg::t_res      n_res;

    // mag*gain = (mag*gain_hi << 16) + mag*gain_lo, plus 2^30 for rounding
    assign w_full = {r_pq, 16'd0}
                  + {{(PROD_W-PP_W){1'b0}}, r_pa}
                  + (PROD_W'(1) << 30);

    always_comb begin
        n_res.sat   = 1'b0;
        n_res.value = r_rnd[31:0];
        if (r_p4_neg) begin
            if (r_rnd > RND_W'(33'h0_8000_0000)) begin
                n_res.sat   = 1'b1;
                n_res.value = 32'h8000_0000;
            end else begin
                n_res.value = 32'd0 - r_rnd[31:0];
            end
        end else if (r_rnd > RND_W'(33'h0_7FFF_FFFF)) begin
            n_res.sat   = 1'b1;
            n_res.value = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_neg <= i_sum[SUM_W-1];
        r_mag    <= i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        r_p3_neg <= r_p2_neg;
        r_pq     <= PP_W'(r_mag * i_gain[31:16]);
        r_pa     <= PP_W'(r_mag * i_gain[15:0]);
        r_p4_neg <= r_p3_neg;
        r_rnd    <= w_full[PROD_W-1:31];
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_p5_valid <= 1'b0;
        end else begin
            r_p2_valid <= i_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            r_p5_valid <= r_p4_valid;
        end
    end

    assign o_valid = r_p5_valid;
    assign o_res   = r_res;

endmodule

/* hw/rtl/bxf_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxf_out_fifo
// Small result buffer that decouples the datapath from downstream stalls.
// ----------------------------------------------------------------------------
module bxf_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  bxf_pkg::t_res i_data,
    input  logic          i_rd,
    output logic          o_valid,
    output bxf_pkg::t_res o_data
);

    localparam int unsigned DEPTH = bxf_pkg::FIFO_DEPTH;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    bxf_pkg::t_res r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_wr, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !w_pop) |-> (r_count != CW'(DEPTH)))
        else $error("result buffer overflow");

endmodule

/* hw/rtl/box_fir_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_fir_filter
// Moving-average (box) FIR filter on a Q1.31 sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one Q1.31 sample per beat; m_axis returns one filtered
//   sample per input beat, in order, with tuser[0] set when it was clipped.
//   The cfg channel writes box_gain (value / 2^31); write it only while idle.
//   Throughput is one sample per cycle while s_axis_tready is high: each beat
//   does a single read and a single write of the ring memory, and the running
//   sum takes one add and one subtract per cycle. From input beat to output
//   valid a beat passes ring read, sum update, magnitude, two 16-bit-gain
//   partial products, rounding, saturation and the result buffer.
//   An 8-entry result buffer absorbs receiver stalls; s_axis_tready drops
//   once 8 beats are in flight or buffered, so nothing is lost.
//   Reset clears the running sum, ring position and buffer and loads the
//   default gain of 1/1024. Ring slots not yet written since reset read as
//   zero until the position first wraps, so no clearing pass is needed and
//   the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module box_fir_filter #(
    parameter int unsigned TAPS = bxf_pkg::TAPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] filtered_sample
    output logic [0:0]  m_axis_tuser,   // [0] saturated
    // gain register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned SUM_W = 32 + $clog2(TAPS);
    localparam int unsigned DEPTH = bxf_pkg::FIFO_DEPTH;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [31:0]             r_gain;
    logic [CW-1:0]           r_credit;
    logic                    w_in_acc;
    logic                    w_out_acc;
    logic                    w_sum_valid;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_res_valid;
    bxf_pkg::t_res           w_res;
    bxf_pkg::t_res           w_out;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_credit < CW'(DEPTH));
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= bxf_pkg::GAIN_RESET;
            r_credit <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
            unique case ({w_in_acc, w_out_acc})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
        end
    end

    bxf_ring #(
        .TAPS (TAPS)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_acc),
        .i_sample (s_axis_tdata),
        .o_valid  (w_sum_valid),
        .o_sum    (w_sum)
    );

    bxf_scale #(
        .SUM_W (SUM_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .i_gain  (r_gain),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    bxf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_data  (w_res),
        .i_rd    (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out)
    );

    assign m_axis_tdata = w_out.value;
    assign m_axis_tuser = w_out.sat;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CW'(DEPTH))
        else $error("in-flight count above buffer depth");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_credit != '0))
        else $error("output beat without an accepted input");

endmodule

/* test/tb_box_fir_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_fir_filter
// Self-checking testbench for the box FIR filter.
// ----------------------------------------------------------------------------
// Each sample beat accepted on s_axis updates a local copy of the ring and the
// running sum; each gain write updates a copy of the gain. The copies predict
// the filtered sample and the clip flag, and every m_axis beat is checked
// against the oldest prediction. Directed beats cover rounding at one half,
// full scale, both overflows and the gain extremes. Random phases follow, each
// with its own gain, and the ring wraps past its full length once. A final
// test holds off the receiver long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_box_fir_filter;

    localparam int unsigned TAPS = bxf_pkg::TAPS_DEF;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data    = '0;

    // local copy of the filter state
    logic [31:0] ring_hist [TAPS];
    longint      ring_sum;
    int unsigned ring_pos;
    logic [31:0] gain_reg;

    bxf_pkg::t_res filtered_q [$];

    int unsigned fail_cnt    = 0;
    int unsigned samples_cnt = 0;
    int unsigned results_cnt = 0;
    int unsigned clip_cnt    = 0;
    int unsigned gain_writes = 0;
    int unsigned rx_hold_req = 0;
    bit          tx_idle_en  = 1'b0;
    bit          rx_idle_en  = 1'b0;

    box_fir_filter #(
        .TAPS(TAPS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ring update, exact scaling, round half away from zero, clip
    function automatic void predict_filtered(input logic [31:0] smp);
        logic [47:0]   mag;
        logic [79:0]   prod;
        logic [79:0]   rnd;
        bxf_pkg::t_res res;
        ring_sum = ring_sum - longint'($signed(ring_hist[ring_pos]))
                 + longint'($signed(smp));
        ring_hist[ring_pos] = smp;
        ring_pos = (ring_pos == TAPS - 1) ? 0 : ring_pos + 1;
        mag  = (ring_sum < 0) ? 48'(-ring_sum) : 48'(ring_sum);
        prod = 80'(mag) * 80'(gain_reg) + (80'd1 << 30);
        rnd  = prod >> 31;
        res.sat = 1'b0;
        if (ring_sum < 0) begin
            if (rnd > 80'h8000_0000) begin
                rnd     = 80'h8000_0000;
                res.sat = 1'b1;
            end
            res.value = 32'd0 - rnd[31:0];
        end else begin
            if (rnd > 80'h7FFF_FFFF) begin
                rnd     = 80'h7FFF_FFFF;
                res.sat = 1'b1;
            end
            res.value = rnd[31:0];
        end
        filtered_q.push_back(res);
    endfunction

    function automatic logic [31:0] rand_sample();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom;
            6:       v = 32'($signed($urandom_range(0, 2000)) - 1000);
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic [31:0] smp);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_filtered(smp);
        samples_cnt++;
        if (tx_idle_en && $urandom_range(0, 99) < 30) begin
            gap = idle_len();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering beats and wait for every outstanding result
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (filtered_q.size() != 0);
    endtask

    task automatic write_gain(input logic [31:0] g);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gain_reg = g;
        gain_writes++;
    endtask

    // reset gain of 1/1024; sums of +-512 land exactly on one half
    task automatic test_rounding();
        send_sample(32'd512);
        send_sample(-32'sd1024);
        send_sample(32'd512);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'd1);     // sum back to zero
        wait_drain();
    endtask

    // unity gain: negative full scale is exact, then both overflows
    task automatic test_full_scale();
        write_gain(32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        wait_drain();
    endtask

    task automatic test_gain_extremes();
        write_gain(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        wait_drain();
        write_gain(32'hFFFF_FFFF);  // beyond unity, used as given
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        wait_drain();
        write_gain(32'h0000_0001);
        send_sample(32'h4000_0000);
        send_sample(32'hC000_0000);
        wait_drain();
    endtask

    task automatic test_random_stream();
        logic [31:0] g;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       g = bxf_pkg::GAIN_RESET;
                1:       g = 32'h8000_0000;
                2:       g = $urandom_range(0, 32'h8000_0000);
                3:       g = $urandom_range(32'h0010_0000, 32'h0800_0000);
                4:       g = $urandom;
                5:       g = $urandom_range(1, 32'h0000_FFFF);
                default: g = bxf_pkg::GAIN_RESET;
            endcase
            // one phase runs at full rate on both sides
            tx_idle_en = (ph != 3);
            rx_idle_en = (ph != 3);
            write_gain(g);
            repeat (160) send_sample(rand_sample());
            wait_drain();
        end
    endtask

    // receiver holds off; the result buffer fills and s_axis must stall
    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_hold_req = 300;
        repeat (40) send_sample(rand_sample());
        wait_drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (40) send_sample(rand_sample());
        wait_drain();
    endtask

    // receiver: random stalls, plus a long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_req) @(posedge i_clk);
                rx_hold_req = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
                m_axis_tready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        bxf_pkg::t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (filtered_q.size() == 0) begin
                $error("result beat with nothing expected: filtered_sample=%h saturated=%b",
                       m_axis_tdata, m_axis_tuser[0]);
                fail_cnt++;
            end else begin
                want = filtered_q.pop_front();
                results_cnt++;
                if (want.sat) clip_cnt++;
                if (m_axis_tdata !== want.value) begin
                    $error("filtered_sample: expected %h, got %h", want.value, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tuser[0] !== want.sat) begin
                    $error("saturated: expected %b, got %b", want.sat, m_axis_tuser[0]);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int i = 0; i < TAPS; i++) ring_hist[i] = '0;
        ring_sum = 0;
        ring_pos = 0;
        gain_reg = bxf_pkg::GAIN_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rounding();
        test_full_scale();
        test_gain_extremes();
        test_random_stream();
        test_backpressure();

        repeat (20) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            $error("%0d results never arrived", filtered_q.size());
            fail_cnt++;
        end
        $display("%0d samples in, %0d results checked, %0d of them clipped",
                 samples_cnt, results_cnt, clip_cnt);
        $display("%0d gain writes, ring of %0d taps wrapped, one long receiver hold",
                 gain_writes, TAPS);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
